// File: hw/rtl/drs_pkg.sv
// Shared types and constants for the descending record sorter.
// Used by drs_cell and descending_record_sorter; depends on nothing else.
package drs_pkg;

    // Number of cells in the sorting chain, which is the batch capacity.
    localparam int DEPTH = 32;

    // Field widths of one record.
    localparam int QTY_W  = 31;
    localparam int SHOP_W = 16;
    localparam int TAG_W  = 8;

    // The record counter must hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // One record as it sits in a cell.
    typedef struct packed {
        logic [QTY_W-1:0]  quantity;
        logic [SHOP_W-1:0] shop;
        logic [TAG_W-1:0]  tag;
    } t_rec;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;     // a new word is placed into the sorted chain
        logic shift_out;  // every cell but the last takes the record of its right neighbor
    } t_cell_ctrl;

endpackage

// File: hw/rtl/drs_cell.sv
// One cell of the sorting chain: holds a single record and trades it with
// its neighbors. Depends on drs_pkg for the record and control types.
module drs_cell (
    input  logic                i_clk,
    input  drs_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_empty,
    input  logic                i_prev_takes,
    input  drs_pkg::t_rec       i_prev_rec,
    input  drs_pkg::t_rec       i_next_rec,
    input  drs_pkg::t_rec       i_new_rec,
    output logic                o_takes,
    output drs_pkg::t_rec       o_rec
);

    drs_pkg::t_rec r_rec;
    drs_pkg::t_rec n_rec;

    // The new record belongs at or before this cell when the cell is unused or
    // holds a strictly smaller key; equal keys stay ahead, keeping the sort stable.
    assign o_takes = i_empty || (r_rec.quantity < i_new_rec.quantity);

    // On insert, cells past the insertion point take their left neighbor's
    // record and the first taking cell takes the new one. On drain, all move left.
    always_comb begin
        n_rec = r_rec;
        if (i_ctrl.shift_out) begin
            n_rec = i_next_rec;
        end else if (i_ctrl.insert) begin
            if (i_prev_takes) begin
                n_rec = i_prev_rec;
            end else if (o_takes) begin
                n_rec = i_new_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// File: hw/rtl/descending_record_sorter.sv
// Top level of the descending record sorter: a chain of drs_cell instances
// with the batch counter, drain control and output register. Depends on drs_pkg.

// Records are accepted one per cycle while o_busy is low; each word is placed
// into its sorted position in the cell chain in the same cycle. The word with
// i_last_record closes the batch: o_busy then rises while the chain shifts the
// records held (at most 32) out through cell 0, and the results appear on the
// output ports one per cycle, largest quantity first, the first one shown from the
// clock edge after the one that accepted the closing word. Each result is shown for
// exactly one cycle with o_strobe high and must be taken then; the receiver
// cannot stall the block. Equal quantities leave in arrival order. Records beyond
// the capacity are dropped, and every result of that batch carries o_overflowed.
module descending_record_sorter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [drs_pkg::QTY_W-1:0]  i_quantity,
    input  logic [drs_pkg::SHOP_W-1:0] i_shop_id,
    input  logic [drs_pkg::TAG_W-1:0]  i_item_tag,
    input  logic                       i_last_record,
    output logic                       o_strobe,
    output logic [drs_pkg::QTY_W-1:0]  o_sorted_quantity,
    output logic [drs_pkg::SHOP_W-1:0] o_sorted_shop,
    output logic [drs_pkg::TAG_W-1:0]  o_sorted_tag,
    output logic                       o_run_end,
    output logic                       o_overflowed
);

    localparam int N = drs_pkg::DEPTH;
    localparam int CW = drs_pkg::CNT_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_overflow;
    logic                n_overflow;
    logic                r_draining;
    logic                n_draining;
    logic                r_strobe;
    logic                n_strobe;
    logic                r_run_end;
    logic                n_run_end;
    logic                r_out_ovf;
    logic                n_out_ovf;
    drs_pkg::t_rec       r_out_rec;
    drs_pkg::t_rec       n_out_rec;

    logic                w_accept;
    logic                w_full;
    drs_pkg::t_cell_ctrl w_ctrl;
    drs_pkg::t_rec       w_new_rec;
    drs_pkg::t_rec       w_rec [N];
    logic                w_takes [N];

    assign w_accept = i_start && !r_draining;
    assign w_full   = (r_count == CW'(N));

    assign w_new_rec.quantity = i_quantity;
    assign w_new_rec.shop     = i_shop_id;
    assign w_new_rec.tag      = i_item_tag;

    assign w_ctrl.insert    = w_accept && !w_full;
    assign w_ctrl.shift_out = r_draining;

    // The sorting chain. Cells at or beyond the record count hold nothing valid.
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic          w_empty;
        logic          w_prev_takes;
        drs_pkg::t_rec w_prev_rec;
        drs_pkg::t_rec w_next_rec;

        assign w_empty = (CW'(g) >= r_count);

        if (g == 0) begin : g_first
            assign w_prev_takes = 1'b0;
            assign w_prev_rec   = w_new_rec;
        end else begin : g_mid
            assign w_prev_takes = w_takes[g-1];
            assign w_prev_rec   = w_rec[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_next_rec = w_rec[g];
        end else begin : g_inner
            assign w_next_rec = w_rec[g+1];
        end

        drs_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_empty      (w_empty),
            .i_prev_takes (w_prev_takes),
            .i_prev_rec   (w_prev_rec),
            .i_next_rec   (w_next_rec),
            .i_new_rec    (w_new_rec),
            .o_takes      (w_takes[g]),
            .o_rec        (w_rec[g])
        );
    end

    // Batch bookkeeping and drain sequencing.
    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        n_draining = r_draining;
        n_strobe   = 1'b0;
        n_run_end  = 1'b0;
        n_out_ovf  = r_out_ovf;
        n_out_rec  = r_out_rec;
        if (r_draining) begin
            n_strobe  = 1'b1;
            n_out_rec = w_rec[0];
            n_out_ovf = r_overflow;
            n_run_end = (r_count == CW'(1));
            n_count   = r_count - CW'(1);
            if (r_count == CW'(1)) begin
                n_draining = 1'b0;
                n_overflow = 1'b0;
            end
        end else if (w_accept) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
            if (i_last_record) begin
                n_draining = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_draining <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_draining <= n_draining;
            r_strobe   <= n_strobe;
        end
    end

    // Output payload registers.
    always_ff @(posedge i_clk) begin
        r_run_end <= n_run_end;
        r_out_ovf <= n_out_ovf;
        r_out_rec <= n_out_rec;
    end

    assign o_busy            = r_draining;
    assign o_strobe          = r_strobe;
    assign o_sorted_quantity = r_out_rec.quantity;
    assign o_sorted_shop     = r_out_rec.shop;
    assign o_sorted_tag      = r_out_rec.tag;
    assign o_run_end         = r_run_end;
    assign o_overflowed      = r_out_ovf;

    // The counter never exceeds the chain length.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(N))
        else $error("record count exceeds chain length");

    // A drain never runs on an empty chain.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_count != '0))
        else $error("drain with no records held");

    // The closing word always starts a drain.
    a_close_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_record) |=> o_busy)
        else $error("closing word did not start a drain");

    // When the final word of a batch is shown, the block is free again.
    a_end_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_run_end) |-> !o_busy)
        else $error("block still busy after final result");

    // The head of the chain is never smaller than its neighbor.
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_rec[0].quantity >= w_rec[1].quantity))
        else $error("chain out of order at its head");

endmodule

// File: dv/tb_descending_record_sorter.sv
// Self-checking testbench for descending_record_sorter: it loads record batches and checks
// every sorted result against a predicted descending, arrival-stable order.
// Depends on drs_pkg and the descending_record_sorter RTL.
module tb_descending_record_sorter;

    // One record word waiting to be driven, with the idle cycles that precede it.
    typedef struct {
        logic [drs_pkg::QTY_W-1:0]  quantity;
        logic [drs_pkg::SHOP_W-1:0] shop;
        logic [drs_pkg::TAG_W-1:0]  tag;
        logic                       last;
        int unsigned                gap;
    } t_word;

    // One sorted record as the block should emit it.
    typedef struct {
        drs_pkg::t_rec rec;
        logic          run_end;
        logic          overflowed;
    } t_sorted;

    localparam logic [drs_pkg::QTY_W-1:0] QTY_MAX = {drs_pkg::QTY_W{1'b1}};

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_start = 1'b0;
    logic [drs_pkg::QTY_W-1:0]  i_quantity = '0;
    logic [drs_pkg::SHOP_W-1:0] i_shop_id = '0;
    logic [drs_pkg::TAG_W-1:0]  i_item_tag = '0;
    logic                       i_last_record = 1'b0;
    logic                       o_busy;
    logic                       o_strobe;
    logic [drs_pkg::QTY_W-1:0]  o_sorted_quantity;
    logic [drs_pkg::SHOP_W-1:0] o_sorted_shop;
    logic [drs_pkg::TAG_W-1:0]  o_sorted_tag;
    logic                       o_run_end;
    logic                       o_overflowed;

    // Words still to be driven and sorted records still to arrive.
    t_word   pending_words[$];
    t_sorted sorted_due[$];

    // Predicted batch: kept in descending order as each word arrives.
    drs_pkg::t_rec batch_recs[drs_pkg::DEPTH];
    int unsigned   batch_len = 0;
    logic          batch_dropped = 1'b0;

    // Driver state.
    t_word       cur_word;
    logic        word_loaded = 1'b0;
    int unsigned hold_left = 0;
    logic        fire;

    int unsigned mismatches = 0;
    int unsigned words_queued = 0;

    descending_record_sorter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_quantity        (i_quantity),
        .i_shop_id         (i_shop_id),
        .i_item_tag        (i_item_tag),
        .i_last_record     (i_last_record),
        .o_strobe          (o_strobe),
        .o_sorted_quantity (o_sorted_quantity),
        .o_sorted_shop     (o_sorted_shop),
        .o_sorted_tag      (o_sorted_tag),
        .o_run_end         (o_run_end),
        .o_overflowed      (o_overflowed)
    );

    always #1 i_clk = ~i_clk;

    // Place an accepted word into the predicted batch; a closing word releases the batch.
    task automatic take_record(input t_word w);
        drs_pkg::t_rec r;
        t_sorted s;
        int k;
        r.quantity = w.quantity;
        r.shop = w.shop;
        r.tag = w.tag;
        if (batch_len < drs_pkg::DEPTH) begin
            // Walk past strictly smaller keys only, so equal keys keep arrival order.
            k = batch_len;
            while (k > 0 && batch_recs[k-1].quantity < r.quantity) begin
                batch_recs[k] = batch_recs[k-1];
                k--;
            end
            batch_recs[k] = r;
            batch_len++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (w.last) begin
            for (k = 0; k < batch_len; k++) begin
                s.rec = batch_recs[k];
                s.run_end = (k == batch_len - 1);
                s.overflowed = batch_dropped;
                sorted_due.push_back(s);
            end
            batch_len = 0;
            batch_dropped = 1'b0;
        end
    endtask

    task automatic add_word(input logic [drs_pkg::QTY_W-1:0] q,
                            input logic [drs_pkg::SHOP_W-1:0] s,
                            input logic [drs_pkg::TAG_W-1:0] t, input logic last,
                            input int unsigned gap);
        t_word w;
        w.quantity = q;
        w.shop = s;
        w.tag = t;
        w.last = last;
        w.gap = gap;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Key styles: full range, a narrow range that forces ties, or the extremes.
    function automatic logic [drs_pkg::QTY_W-1:0] draw_quantity(input int unsigned style);
        logic [drs_pkg::QTY_W-1:0] q;
        case (style)
            0: q = drs_pkg::QTY_W'($urandom());
            1: q = drs_pkg::QTY_W'($urandom_range(0, 3));
            default: begin
                case ($urandom_range(0, 3))
                    0: q = '0;
                    1: q = drs_pkg::QTY_W'(1);
                    2: q = QTY_MAX - drs_pkg::QTY_W'(1);
                    default: q = QTY_MAX;
                endcase
            end
        endcase
        return q;
    endfunction

    function automatic logic [drs_pkg::SHOP_W-1:0] draw_shop();
        logic [drs_pkg::SHOP_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = {drs_pkg::SHOP_W{1'b1}};
            default: s = drs_pkg::SHOP_W'($urandom());
        endcase
        return s;
    endfunction

    // A whole batch with random content; some batches run with no idle cycles at all.
    task automatic add_batch(input int unsigned size);
        int unsigned style;
        logic idle_free;
        int unsigned k;
        style = $urandom_range(0, 2);
        idle_free = ($urandom_range(0, 2) == 0);
        for (k = 0; k < size; k++) begin
            add_word(draw_quantity(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : style),
                     draw_shop(), drs_pkg::TAG_W'($urandom()), (k == size - 1),
                     idle_free ? 0 : $urandom_range(0, 17));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: presents one word at a time, each after its drawn idle cycles.
    always @(posedge i_clk) begin
        fire = 1'b0;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                take_record(cur_word);
                word_loaded = 1'b0;
            end
            if (!word_loaded && pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                hold_left = cur_word.gap;
                word_loaded = 1'b1;
            end
            if (word_loaded) begin
                if (hold_left == 0) begin
                    fire = 1'b1;
                end else begin
                    hold_left--;
                end
            end
        end
        i_start <= fire;
        if (fire) begin
            i_quantity <= cur_word.quantity;
            i_shop_id <= cur_word.shop;
            i_item_tag <= cur_word.tag;
            i_last_record <= cur_word.last;
        end
    end

    // Monitor: every strobed result must match the oldest record due.
    always @(posedge i_clk) begin
        t_sorted due;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (sorted_due.size() == 0) begin
                $error("result with no record due: quantity %0d, shop %0d, tag %0d",
                       o_sorted_quantity, o_sorted_shop, o_sorted_tag);
                mismatches++;
            end else begin
                due = sorted_due.pop_front();
                check_field("sorted_quantity", 32'(o_sorted_quantity),
                            32'(due.rec.quantity));
                check_field("sorted_shop", 32'(o_sorted_shop), 32'(due.rec.shop));
                check_field("sorted_tag", 32'(o_sorted_tag), 32'(due.rec.tag));
                check_field("run_end", 32'(o_run_end), 32'(due.run_end));
                check_field("overflowed", 32'(o_overflowed), 32'(due.overflowed));
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        // Single record at the top of every field.
        add_word(QTY_MAX, {drs_pkg::SHOP_W{1'b1}}, {drs_pkg::TAG_W{1'b1}}, 1'b1, 0);
        // Zero keys and zero payload; the two zero keys must stay in arrival order.
        add_word('0, '0, 8'd0, 1'b0, 0);
        add_word(31'd1, 16'd1, 8'd1, 1'b0, 0);
        add_word('0, 16'd2, 8'd2, 1'b1, 3);
        // All keys equal: output order is arrival order.
        for (int k = 0; k < 5; k++) begin
            add_word(31'd7, drs_pkg::SHOP_W'(100 + k), drs_pkg::TAG_W'(10 + k), (k == 4), 0);
        end
        // Ascending input is fully reversed.
        add_word(31'd1, 16'd11, 8'd21, 1'b0, 1);
        add_word(31'd2, 16'd12, 8'd22, 1'b0, 0);
        add_word(31'd3, 16'd13, 8'd23, 1'b0, 2);
        add_word(QTY_MAX, 16'd14, 8'd24, 1'b1, 0);
        // Already descending input passes through unchanged.
        add_word(QTY_MAX, 16'd31, 8'd41, 1'b0, 0);
        add_word(QTY_MAX - drs_pkg::QTY_W'(1), 16'd32, 8'd42, 1'b0, 0);
        add_word(31'd5, 16'd33, 8'd43, 1'b0, 0);
        add_word('0, 16'd34, 8'd44, 1'b1, 0);

        // A batch that exactly fills the store, then one whose closing word is dropped.
        add_batch(drs_pkg::DEPTH);
        add_batch(drs_pkg::DEPTH + 1);
        // Mostly short batches, now and then one that overflows.
        while (words_queued < 170) begin
            if ($urandom_range(0, 9) == 0) begin
                add_batch($urandom_range(drs_pkg::DEPTH + 1, drs_pkg::DEPTH + 4));
            end else begin
                add_batch($urandom_range(1, 10));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || word_loaded || sorted_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (2 * drs_pkg::DEPTH + 8) @(posedge i_clk);

        if (mismatches == 0 && sorted_due.size() == 0) begin
            $display("tb_descending_record_sorter OK");
        end else begin
            $display("tb_descending_record_sorter NOT OK");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #400000;
        $display("tb_descending_record_sorter NOT OK");
        $finish;
    end

endmodule
